/* design/frame_bitmap_allocator_top_defines.svh */
// Assertion macros shared by the frame bitmap allocator RTL.
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge of i_clk outside reset.
`define FBA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame bitmap allocator check failed");

// Next-cycle implication, checked on every rising edge of i_clk outside reset.
`define FBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame bitmap allocator check failed");

`else

`define FBA_ASSERT_IMPL(label, ante, cons)

`define FBA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/fba_pkg.sv */
// Types, constants and helper functions of the frame bitmap allocator.
package fba_pkg;

    localparam int FRAME_W        = 12;
    localparam int CNT_W          = 13;
    localparam int STATUS_W       = 3;
    localparam int WORD_BITS      = 32;
    localparam int BIT_W          = 5;
    localparam int FBA_MAX_FRAMES = 4096;
    localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 13'h1000;

    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_word WORD_ONES = 32'hFFFF_FFFF;

    // Operation codes of an input item.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_MAPPED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FREED     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTHING   = 3'd4;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic                present;
        logic                writable;
        logic                user_mode;
        logic [STATUS_W-1:0] status;
    } t_result;

    function automatic t_result mk_result(input logic [FRAME_W-1:0] frame,
                                          input logic present,
                                          input logic writable,
                                          input logic user_mode,
                                          input logic [STATUS_W-1:0] status);
        t_result r;
        r.frame     = frame;
        r.present   = present;
        r.writable  = writable;
        r.user_mode = user_mode;
        r.status    = status;
        return r;
    endfunction

    // Index of the lowest clear bit of a word; zero when the word is full.
    function automatic logic [BIT_W-1:0] lowest_zero(input t_word word);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

/* design/fba_if.sv */
// Handshake channels of the frame bitmap allocator: input items and result items.
interface fba_item_if import fba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [FRAME_W-1:0] page_frame;
    logic               kernel_only;
    logic               write_ok;

    modport source (output valid, kind, page_frame, kernel_only, write_ok, input ready);
    modport sink   (input valid, kind, page_frame, kernel_only, write_ok, output ready);
endinterface

interface fba_result_if import fba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  frame;
    logic                present;
    logic                writable;
    logic                user_mode;
    logic [STATUS_W-1:0] status;

    modport source (output valid, frame, present, writable, user_mode, status, input ready);
    modport sink   (input valid, frame, present, writable, user_mode, status, output ready);
endinterface

/* design/frame_bitmap_allocator_top.sv */
// Top level of the first-fit frame bitmap allocator.
//
// The block tracks physical frames in a bitmap held in a single synchronous RAM of
// 32-bit words, one bit per frame, where a set bit marks a frame in use. An allocate
// item with a nonzero current frame is reported as already mapped. An allocate item
// with a zero frame scans the words below frame_count/32 from word 0 upward, one word
// per cycle through the RAM read port, takes the lowest clear bit, sets it and returns
// the frame with present, writable and user flags. A free item clears the frame's bit.
// Before the result is loaded into a free output register, an already mapped item,
// a nothing-to-free item or an allocation with no whole word to scan goes straight
// to the result state, a free item reads its word and then writes it back, and an
// allocation scans until it finds a clear bit or has checked min(frame_count/32,
// MAX_FRAMES/32) words, which is 128 words for a full 4096-frame bitmap.
// The scan rate is set by the single read port of the bitmap RAM. One item is in
// work at a time; the next item is accepted while a finished result still waits in
// the output register. After reset the bitmap RAM is cleared one word per cycle,
// MAX_FRAMES/32 words (128 at the default), and no item is accepted during that
// pass; configuration writes are taken at any time.
`include "frame_bitmap_allocator_top_defines.svh"

module frame_bitmap_allocator_top import fba_pkg::*; #(
    parameter int MAX_FRAMES = FBA_MAX_FRAMES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    fba_item_if.sink         i_item,
    fba_result_if.source     o_result
);

    // Bitmap geometry derived from the number of frames the RAM holds.
    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(WORDS + 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_FREE_WR = 3'd3;
    localparam logic [2:0] S_RESULT  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [AW-1:0]    r_chk, n_chk;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_kernel, n_kernel;
    logic             r_wr, n_wr;
    t_result          r_pend, n_pend;
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_frame_count;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_word            mem_wdata;
    logic [AW-1:0]    mem_raddr;
    t_word            mem_rdata;

    logic             in_acc;
    logic [CW-1:0]    limit;
    logic [CW-1:0]    chk_nxt;
    logic [6:0]       pf_word;
    logic             pf_in_range;
    logic [BIT_W-1:0] zb;

    fba_bitmap_mem #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Items are taken only while the sequencer rests; the output register is separate,
    // so a waiting result does not hold back the next item.
    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc       = i_item.valid && i_item.ready;

    // Only whole words are scanned, and never past the end of the bitmap.
    always_comb begin
        if (32'(r_frame_count[CNT_W-1:BIT_W]) >= WORDS) begin
            limit = CW'(WORDS);
        end else begin
            limit = CW'(r_frame_count[CNT_W-1:BIT_W]);
        end
    end

    assign chk_nxt     = CW'(r_chk) + 1'b1;
    assign pf_word     = i_item.page_frame[FRAME_W-1:BIT_W];
    assign pf_in_range = (32'(pf_word) < WORDS);
    assign zb          = lowest_zero(mem_rdata);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_chk       = r_chk;
        n_waddr     = r_waddr;
        n_bit       = r_bit;
        n_kernel    = r_kernel;
        n_wr        = r_wr;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;
        mem_we      = 1'b0;
        mem_waddr   = r_waddr;
        mem_wdata   = '0;
        mem_raddr   = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (32'(r_clr) == WORDS - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_kernel = i_item.kernel_only;
                    n_wr     = i_item.write_ok;
                    n_waddr  = AW'(pf_word);
                    n_bit    = i_item.page_frame[BIT_W-1:0];
                    priority if (i_item.kind == KIND_ALLOC && i_item.page_frame != '0) begin
                        n_pend  = mk_result(i_item.page_frame, 1'b0, 1'b0, 1'b0, STAT_MAPPED);
                        n_state = S_RESULT;
                    end else if (i_item.kind == KIND_ALLOC && limit == '0) begin
                        n_pend  = mk_result('0, 1'b0, 1'b0, 1'b0, STAT_EXHAUSTED);
                        n_state = S_RESULT;
                    end else if (i_item.kind == KIND_ALLOC) begin
                        // Word 0 is read at this edge; the scan checks it next cycle.
                        mem_raddr = '0;
                        n_chk     = '0;
                        n_state   = S_SCAN;
                    end else if (i_item.page_frame == '0) begin
                        n_pend  = mk_result('0, 1'b0, 1'b0, 1'b0, STAT_NOTHING);
                        n_state = S_RESULT;
                    end else if (pf_in_range) begin
                        mem_raddr = AW'(pf_word);
                        n_state   = S_FREE_WR;
                    end else begin
                        n_pend  = mk_result('0, 1'b0, 1'b0, 1'b0, STAT_FREED);
                        n_state = S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                if (mem_rdata != WORD_ONES) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_chk;
                    mem_wdata = mem_rdata | (t_word'(1) << zb);
                    n_pend    = mk_result(FRAME_W'({r_chk, zb}), 1'b1, r_wr, !r_kernel,
                                          STAT_ALLOCATED);
                    n_state   = S_RESULT;
                end else if (chk_nxt == limit) begin
                    n_pend  = mk_result('0, 1'b0, 1'b0, 1'b0, STAT_EXHAUSTED);
                    n_state = S_RESULT;
                end else begin
                    // The next word is read while this one is being checked.
                    n_chk     = AW'(chk_nxt);
                    mem_raddr = AW'(chk_nxt);
                end
            end
            S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                mem_wdata = mem_rdata & ~(t_word'(1) << r_bit);
                n_pend    = mk_result('0, 1'b0, 1'b0, 1'b0, STAT_FREED);
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
            r_frame_count <= FRAME_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk    <= n_chk;
        r_waddr  <= n_waddr;
        r_bit    <= n_bit;
        r_kernel <= n_kernel;
        r_wr     <= n_wr;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.frame     = r_out.frame;
    assign o_result.present   = r_out.present;
    assign o_result.writable  = r_out.writable;
    assign o_result.user_mode = r_out.user_mode;
    assign o_result.status    = r_out.status;

    // The bitmap is only written while clearing, scanning or freeing.
    `FBA_ASSERT_IMPL(a_quiet_mem, (r_state == S_IDLE || r_state == S_RESULT), !mem_we)
    // The word under check always lies inside the scanned range.
    `FBA_ASSERT_IMPL(a_scan_bound, r_state == S_SCAN, 32'(r_chk) < 32'(limit))
    // A scan either continues or ends with a result.
    `FBA_ASSERT_NEXT(a_scan_exit, r_state == S_SCAN, (r_state == S_SCAN || r_state == S_RESULT))
    // An accepted item always takes the sequencer out of its resting state.
    `FBA_ASSERT_NEXT(a_accept_busy, in_acc, r_state != S_IDLE)

endmodule

/* design/fba_bitmap_mem.sv */
// Frame bitmap storage: one write port and one read port with registered read data.
module fba_bitmap_mem import fba_pkg::*; #(
    parameter int DEPTH = FBA_MAX_FRAMES / WORD_BITS,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_word         o_rdata
);

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the first-fit frame bitmap allocator.
`timescale 1ns / 100ps

module tb;
    import fba_pkg::*;

    // Longest stretch of cycles in which no item and no result may be accepted.
    // It must cover a full 128-word scan, a receiver stall and a sender gap, and
    // the clearing pass after reset. The limit is several times the sum of these.
    localparam int QUIET_LIMIT  = 2000;
    localparam int BITMAP_WORDS = FBA_MAX_FRAMES / WORD_BITS;
    // Settling time after the last result: one full scan plus margin.
    localparam int SETTLE_CYCLES = 140;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    fba_item_if   item_if ();
    fba_result_if result_if ();

    frame_bitmap_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    always #1 i_clk = ~i_clk;

    // The testbench keeps its own view of the allocator. There is one bit per
    // frame, packed in 32-bit words, and a copy of the frame count register.
    logic [WORD_BITS-1:0] frame_bits [BITMAP_WORDS];
    logic [CNT_W-1:0]     frame_count_copy;

    // Page entries that the block should return, in order of acceptance.
    t_result              pending_entries [$];
    // Frames that the block handed out. The random stimulus frees these.
    logic [FRAME_W-1:0]   held_frames [$];

    int  fail_count  = 0;
    int  quiet_count = 0;
    int  burst_left  = 0;
    int  stall_left  = 0;
    bit  tx_gaps     = 1'b0;
    bit  rx_stalls   = 1'b0;

    // Compute the page entry that one item yields, and update the bitmap copy.
    // An allocation scans only the whole words below frame_count/32. The scan
    // stops at the end of the bitmap when the count is larger than the bitmap.
    function automatic t_result predict_frame_op(input logic kind,
                                                 input logic [FRAME_W-1:0] page_frame,
                                                 input logic kernel_only,
                                                 input logic write_ok);
        t_result            entry;
        int                 words;
        bit                 found;
        logic [FRAME_W-1:0] pick;
        entry = '0;
        found = 1'b0;
        pick  = '0;
        if (kind == KIND_ALLOC) begin
            if (page_frame != '0) begin
                entry.frame  = page_frame;
                entry.status = STAT_MAPPED;
            end else begin
                words = int'(frame_count_copy) / WORD_BITS;
                if (words > BITMAP_WORDS) begin
                    words = BITMAP_WORDS;
                end
                for (int w = 0; w < words && !found; w++) begin
                    if (frame_bits[w] != WORD_ONES) begin
                        for (int b = 0; b < WORD_BITS && !found; b++) begin
                            if (!frame_bits[w][b]) begin
                                found = 1'b1;
                                pick  = FRAME_W'(w * WORD_BITS + b);
                            end
                        end
                    end
                end
                if (!found) begin
                    entry.status = STAT_EXHAUSTED;
                end else begin
                    frame_bits[pick[FRAME_W-1:BIT_W]][pick[BIT_W-1:0]] = 1'b1;
                    entry.frame     = pick;
                    entry.present   = 1'b1;
                    entry.writable  = write_ok;
                    entry.user_mode = ~kernel_only;
                    entry.status    = STAT_ALLOCATED;
                end
            end
        end else begin
            if (page_frame == '0) begin
                entry.status = STAT_NOTHING;
            end else begin
                // A frame that is already clear, or one past the count, is
                // still reported as freed.
                frame_bits[page_frame[FRAME_W-1:BIT_W]][page_frame[BIT_W-1:0]] = 1'b0;
                entry.status = STAT_FREED;
            end
        end
        return entry;
    endfunction

    task automatic log_failure(input string what, input t_result want, input t_result got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t %s: expected frame=%0d present=%0b writable=%0b user=%0b status=%0d,",
                     $time, what, want.frame, want.present, want.writable, want.user_mode,
                     want.status,
                     " actual frame=%0d present=%0b writable=%0b user=%0b status=%0d",
                     got.frame, got.present, got.writable, got.user_mode, got.status);
        end
    endtask

    // Send one item. With gaps on, the sender works in bursts. When a burst is used
    // up, valid drops for a random gap before the next item. Valid stays high from one
    // item to the next inside a burst. The expected entry is computed at the
    // edge that accepts the item.
    task automatic send_item(input logic kind, input logic [FRAME_W-1:0] page_frame,
                             input logic kernel_only, input logic write_ok);
        t_result entry;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                @(negedge i_clk);
                item_if.valid <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge i_clk);
        item_if.valid       <= 1'b1;
        item_if.kind        <= kind;
        item_if.page_frame  <= page_frame;
        item_if.kernel_only <= kernel_only;
        item_if.write_ok    <= write_ok;
        do @(posedge i_clk); while (!item_if.ready);
        entry = predict_frame_op(kind, page_frame, kernel_only, write_ok);
        pending_entries.push_back(entry);
        if (entry.status == STAT_ALLOCATED) begin
            held_frames.push_back(entry.frame);
        end
    endtask

    // Stop sending and wait until every expected entry has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_entries.size() != 0) @(posedge i_clk);
    endtask

    // The block must be idle when frame_count is written.
    task automatic write_frame_count(input logic [CNT_W-1:0] count);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        frame_count_copy = count;
    endtask

    // Draw one random item. Most items are allocations, or frees of frames the
    // block handed out. The rest are noise: allocations for pages that are
    // already mapped, frees of arbitrary frames, and frees with no frame.
    task automatic issue_random_request(input int alloc_pct);
        int                 roll;
        int                 idx;
        logic [FRAME_W-1:0] victim;
        roll = $urandom_range(0, 99);
        // Now and then the sender holds off until the block is drained.
        if ($urandom_range(0, 79) == 0) begin
            wait_drained();
        end
        if (roll < alloc_pct) begin
            send_item(KIND_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (roll < alloc_pct + 10) begin
            send_item(KIND_ALLOC, FRAME_W'($urandom_range(1, 4095)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (roll < alloc_pct + 14) begin
            send_item(KIND_FREE, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (roll < alloc_pct + 22 || held_frames.size() == 0) begin
            send_item(KIND_FREE, FRAME_W'($urandom_range(1, 4095)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            idx    = $urandom_range(0, held_frames.size() - 1);
            victim = held_frames[idx];
            held_frames.delete(idx);
            send_item(KIND_FREE, victim, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Corner cases at the default count and at the extremes of the register.
    task automatic test_directed();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
        write_frame_count(13'd4096);
        // Frame 0 is an ordinary frame and is the first to be handed out.
        send_item(KIND_ALLOC, 12'd0, 1'b0, 1'b1);
        send_item(KIND_ALLOC, 12'd0, 1'b1, 1'b0);
        // Pages that already hold a frame are left alone.
        send_item(KIND_ALLOC, 12'd4095, 1'b1, 1'b1);
        send_item(KIND_ALLOC, 12'd1, 1'b0, 1'b0);
        // A free with no frame does nothing. The flags play no part.
        send_item(KIND_FREE, 12'd0, 1'b1, 1'b1);
        send_item(KIND_FREE, 12'd1, 1'b0, 1'b0);
        // The freed frame is the lowest clear bit again.
        send_item(KIND_ALLOC, 12'd0, 1'b1, 1'b1);
        // Freeing the top frame, which was never taken, still reports freed.
        send_item(KIND_FREE, 12'd4095, 1'b0, 1'b1);
        // A second free of the same frame finds the bit already clear.
        send_item(KIND_FREE, 12'd1, 1'b1, 1'b0);
        send_item(KIND_FREE, 12'd1, 1'b0, 1'b0);
        // With no frames managed every allocation runs out. A free past the
        // count is still reported as freed.
        write_frame_count(13'd0);
        send_item(KIND_ALLOC, 12'd0, 1'b0, 1'b1);
        send_item(KIND_FREE, 12'd5, 1'b0, 1'b0);
        send_item(KIND_ALLOC, 12'd0, 1'b1, 1'b0);
        // A partial last word is never scanned.
        write_frame_count(13'd31);
        send_item(KIND_ALLOC, 12'd0, 1'b0, 1'b0);
        write_frame_count(13'd32);
        send_item(KIND_ALLOC, 12'd0, 1'b0, 1'b1);
        send_item(KIND_ALLOC, 12'd0, 1'b1, 1'b1);
        // A count above the bitmap size saturates at the end of the bitmap.
        write_frame_count(13'd8191);
        send_item(KIND_ALLOC, 12'd0, 1'b1, 1'b0);
        send_item(KIND_FREE, 12'd2, 1'b1, 1'b1);
        send_item(KIND_ALLOC, 12'd0, 1'b0, 1'b1);
        wait_drained();
    endtask

    // Small pools run out of frames quickly. This covers exhaustion, a full
    // first word, and reuse of freed frames.
    task automatic test_small_pool();
        logic [CNT_W-1:0] counts [5];
        counts = '{13'd32, 13'd64, 13'd45, 13'd96, 13'd160};
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        foreach (counts[i]) begin
            write_frame_count(counts[i]);
            repeat (80) issue_random_request(60);
        end
        wait_drained();
    endtask

    // At the reset count, allocations build up so that scans get longer.
    task automatic test_full_pool();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        write_frame_count(FRAME_COUNT_RST);
        repeat (400) issue_random_request(55);
        wait_drained();
    endtask

    // This run uses the largest register value, with no gaps and no stalls.
    task automatic test_saturated_count();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        write_frame_count(13'd8191);
        repeat (200) issue_random_request(50);
        wait_drained();
    endtask

    // Each phase takes a random count over the whole register range.
    task automatic test_random_counts();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (3) begin
            write_frame_count(CNT_W'($urandom_range(0, 8191)));
            repeat (50) issue_random_request(55);
        end
        wait_drained();
    endtask

    // The receiver has its own stall pattern. It makes short random drops of
    // ready, and now and then a long stall.
    always @(negedge i_clk) begin
        if (!rx_stalls) begin
            result_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            result_if.ready <= 1'b0;
        end else if ($urandom_range(0, 31) == 0) begin
            stall_left = $urandom_range(4, 24);
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Check each returned page entry against the oldest expected entry.
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.frame     = result_if.frame;
            got.present   = result_if.present;
            got.writable  = result_if.writable;
            got.user_mode = result_if.user_mode;
            got.status    = result_if.status;
            if (pending_entries.size() == 0) begin
                log_failure("result with no item pending", '0, got);
            end else begin
                want = pending_entries.pop_front();
                if (got.frame !== want.frame || got.present !== want.present ||
                    got.writable !== want.writable || got.user_mode !== want.user_mode ||
                    got.status !== want.status) begin
                    log_failure("page entry mismatch", want, got);
                end
            end
        end
    end

    // The watchdog ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
            end
            if (quiet_count >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = '0;
        item_if.valid        = 1'b0;
        item_if.kind         = KIND_ALLOC;
        item_if.page_frame   = '0;
        item_if.kernel_only  = 1'b0;
        item_if.write_ok     = 1'b0;
        result_if.ready      = 1'b0;
        frame_count_copy     = FRAME_COUNT_RST;
        foreach (frame_bits[w]) begin
            frame_bits[w] = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_small_pool();
        test_full_pool();
        test_saturated_count();
        test_random_counts();

        // Let any stray result show up before the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        fail_count += pending_entries.size();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
